// ----- src/hkrb_pkg.sv -----
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared constants and controller/datapath interface types for the
// boot keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    localparam int NUM_KEYS      = 232;
    localparam int NUM_MODIFIERS = 8;
    localparam int REPORT_SLOTS  = 6;
    localparam int SLOT_FIELDS   = 6;
    localparam int MOD_BASE      = NUM_KEYS - NUM_MODIFIERS;
    localparam int KEY_W         = $clog2(MOD_BASE);
    localparam int CODE_W        = 8;
    localparam int POS_W         = 3;

    // forced modifier positions within the modifier byte
    localparam int IDX_LCTRL  = 0;
    localparam int IDX_LSHIFT = 1;
    localparam int IDX_LALT   = 2;

    typedef struct packed {
        logic load_in;
        logic key_wr;
        logic force_set;
        logic force_clr;
        logic scan_clear;
        logic scan_step;
        logic load_out;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic code_ok;
        logic changes;
        logic press;
        logic scan_done;
    } t_status;

endpackage

// ----- src/hkrb_datapath.sv -----
// ----------------------------------------------------------------------------
// hkrb_datapath
// Key map, modifier register, serial slot scanner and output register.
// ----------------------------------------------------------------------------
module hkrb_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hkrb_pkg::t_cmd               i_cmd,
    output hkrb_pkg::t_status            o_status,
    input  logic [hkrb_pkg::CODE_W-1:0]  i_usage_code,
    input  logic                         i_pressed,
    input  logic                         i_force_shift,
    input  logic                         i_force_ctrl,
    input  logic                         i_force_alt,
    output logic [7:0]                   o_modifier_byte,
    output logic [7:0]                   o_slot_0,
    output logic [7:0]                   o_slot_1,
    output logic [7:0]                   o_slot_2,
    output logic [7:0]                   o_slot_3,
    output logic [7:0]                   o_slot_4,
    output logic [7:0]                   o_slot_5,
    output logic                         o_last_report
);

    logic [hkrb_pkg::CODE_W-1:0]   r_code;
    logic                          r_down;
    logic [2:0]                    r_force;
    logic [2:0]                    r_fmask;
    logic [7:0]                    r_mod;
    logic [hkrb_pkg::MOD_BASE-1:0] r_keys;
    logic [hkrb_pkg::CODE_W-1:0]   r_idx;
    logic [hkrb_pkg::POS_W-1:0]    r_pos;
    logic [7:0]                    r_slot [hkrb_pkg::SLOT_FIELDS];

    logic                          w_is_mod;
    logic [hkrb_pkg::CODE_W-1:0]   w_off;
    logic                          w_cur;
    logic [2:0]                    w_fmask;
    logic                          w_hit;

    assign w_is_mod = ({1'b0, r_code} >= 9'(hkrb_pkg::MOD_BASE));
    assign w_off    = r_code - hkrb_pkg::CODE_W'(hkrb_pkg::MOD_BASE);
    assign w_cur    = w_is_mod ? r_mod[w_off[2:0]] : r_keys[r_code[hkrb_pkg::KEY_W-1:0]];
    assign w_fmask  = r_force & ~r_mod[2:0];
    assign w_hit    = r_keys[r_idx[hkrb_pkg::KEY_W-1:0]]
                      && (r_pos < hkrb_pkg::POS_W'(hkrb_pkg::REPORT_SLOTS));

    assign o_status.code_ok   = (r_code != '0)
                                && ({1'b0, r_code} < 9'(hkrb_pkg::NUM_KEYS));
    assign o_status.changes   = (w_cur != r_down);
    assign o_status.press     = r_down;
    assign o_status.scan_done = (r_idx == hkrb_pkg::CODE_W'(hkrb_pkg::MOD_BASE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= '0;
            r_keys <= '0;
        end else begin
            if (i_cmd.key_wr) begin
                if (w_is_mod) begin
                    r_mod[w_off[2:0]] <= r_down;
                end else begin
                    r_keys[r_code[hkrb_pkg::KEY_W-1:0]] <= r_down;
                end
            end else if (i_cmd.force_set) begin
                r_mod[2:0] <= r_mod[2:0] | w_fmask;
            end else if (i_cmd.force_clr) begin
                r_mod[2:0] <= r_mod[2:0] & ~r_fmask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_code  <= i_usage_code;
            r_down  <= i_pressed;
            r_force <= {i_force_alt, i_force_shift, i_force_ctrl};
        end
        if (i_cmd.force_set) begin
            r_fmask <= w_fmask;
        end
    end

    // serial scan of the non-modifier keys, lowest code first
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clear) begin
            r_idx <= hkrb_pkg::CODE_W'(1);
            r_pos <= '0;
            for (int k = 0; k < hkrb_pkg::SLOT_FIELDS; k++) begin
                r_slot[k] <= '0;
            end
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + hkrb_pkg::CODE_W'(1);
            if (w_hit) begin
                r_slot[r_pos] <= r_idx;
                r_pos         <= r_pos + hkrb_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_modifier_byte <= r_mod;
            o_slot_0        <= r_slot[0];
            o_slot_1        <= r_slot[1];
            o_slot_2        <= r_slot[2];
            o_slot_3        <= r_slot[3];
            o_slot_4        <= r_slot[4];
            o_slot_5        <= r_slot[5];
            o_last_report   <= i_cmd.last;
        end
    end

endmodule

// ----- src/hkrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkrb_ctrl
// Sequencer: checks the event, orders the report phases and runs the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module hkrb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  hkrb_pkg::t_status    i_status,
    output hkrb_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_LOAD,
        ST_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_MODS,
        PH_KEY,
        PH_LAST
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_in_stall;
    logic   r_out_valid;

    assign o_stall = r_in_stall;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!(i_status.code_ok && i_status.changes)) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = ST_SCAN;
                    if (i_status.press) begin
                        o_cmd.force_set = 1'b1;
                        n_phase         = PH_MODS;
                    end else begin
                        o_cmd.key_wr = 1'b1;
                        n_phase      = PH_LAST;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_out = 1'b1;
                o_cmd.last     = (r_phase == PH_LAST);
                n_state        = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_stall) begin
                    unique case (r_phase)
                        PH_MODS: begin
                            o_cmd.key_wr     = 1'b1;
                            o_cmd.scan_clear = 1'b1;
                            n_phase          = PH_KEY;
                            n_state          = ST_SCAN;
                        end
                        PH_KEY: begin
                            o_cmd.force_clr  = 1'b1;
                            o_cmd.scan_clear = 1'b1;
                            n_phase          = PH_LAST;
                            n_state          = ST_SCAN;
                        end
                        PH_LAST: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_MODS;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_in_stall  <= (n_state != ST_IDLE);
            r_out_valid <= (n_state == ST_WAIT);
        end
    end

endmodule

// ----- src/hid_keyboard_report_builder.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder
// Boot keyboard report builder: key events in, 8-byte reports out.
// ----------------------------------------------------------------------------
// Takes one key event at a time and keeps a map of held keys. Each report is
// built by a serial scan over the non-modifier part of the map, one code per
// cycle, and is then held until the output side takes it. A release that
// changes the map gives one report, a press three. An event that changes
// nothing is dropped without a report. The next event is taken once the last
// report of the current one has been transferred.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_usage_code,
    input  logic       i_pressed,
    input  logic       i_force_shift,
    input  logic       i_force_ctrl,
    input  logic       i_force_alt,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_modifier_byte,
    output logic [7:0] o_slot_0,
    output logic [7:0] o_slot_1,
    output logic [7:0] o_slot_2,
    output logic [7:0] o_slot_3,
    output logic [7:0] o_slot_4,
    output logic [7:0] o_slot_5,
    output logic       o_last_report
);

    hkrb_pkg::t_cmd    w_cmd;
    hkrb_pkg::t_status w_status;

    hkrb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    hkrb_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_usage_code    (i_usage_code),
        .i_pressed       (i_pressed),
        .i_force_shift   (i_force_shift),
        .i_force_ctrl    (i_force_ctrl),
        .i_force_alt     (i_force_alt),
        .o_modifier_byte (o_modifier_byte),
        .o_slot_0        (o_slot_0),
        .o_slot_1        (o_slot_1),
        .o_slot_2        (o_slot_2),
        .o_slot_3        (o_slot_3),
        .o_slot_4        (o_slot_4),
        .o_slot_5        (o_slot_5),
        .o_last_report   (o_last_report)
    );

    // no new event while a report is pending
    a_busy_while_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("event accepted while report pending");

    // an accepted event never shows a report in the next cycle
    a_no_instant_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("report without scan");

    // after the final report transfer the block is ready again
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_report) |=> !o_stall)
        else $error("not ready after last report");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boot keyboard report builder. A directed table
// of key events (ignored codes, repeats, forced modifiers, slot overflow) is
// followed by random typing. Each transfer is compared with a report from the
// table or a behavioural copy of the key map. Both sides pause in random
// bursts; the output side once holds off long enough to block the input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT         = 2000000;
    localparam int RANDOM_EVENTS = 225;
    localparam int DRAIN_CYCLES  = 3 * hkrb_pkg::MOD_BASE + 100;
    localparam int HOLD_CYCLES   = 3000;

    localparam int CODE_LCTRL  = hkrb_pkg::MOD_BASE + hkrb_pkg::IDX_LCTRL;
    localparam int CODE_LSHIFT = hkrb_pkg::MOD_BASE + hkrb_pkg::IDX_LSHIFT;
    localparam int CODE_LALT   = hkrb_pkg::MOD_BASE + hkrb_pkg::IDX_LALT;
    localparam int KEY_RGUI    = hkrb_pkg::MOD_BASE + hkrb_pkg::NUM_MODIFIERS - 1;
    localparam int KEY_TOP     = hkrb_pkg::MOD_BASE - 1;

    localparam logic [7:0] MASK_LCTRL  = 8'(1 << hkrb_pkg::IDX_LCTRL);
    localparam logic [7:0] MASK_LSHIFT = 8'(1 << hkrb_pkg::IDX_LSHIFT);
    localparam logic [7:0] MASK_LALT   = 8'(1 << hkrb_pkg::IDX_LALT);

    typedef struct packed {
        logic [7:0]                            mods;
        logic [hkrb_pkg::SLOT_FIELDS-1:0][7:0] slot;
        logic                                  last;
    } t_report;

    typedef struct packed {
        logic [7:0]        code;
        logic              down;
        logic              fs;
        logic              fc;
        logic              fa;
        logic              typed;
        logic [1:0]        n_typed;
        t_report [2:0]     rep;
    } t_key_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_usage_code  = '0;
    logic       i_pressed     = 1'b0;
    logic       i_force_shift = 1'b0;
    logic       i_force_ctrl  = 1'b0;
    logic       i_force_alt   = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_modifier_byte;
    logic [7:0] o_slot_0, o_slot_1, o_slot_2, o_slot_3, o_slot_4, o_slot_5;
    logic       o_last_report;

    bit          held_keys [0:255];
    t_report     event_reports [3];
    t_report     pending_reports [$];
    t_key_row    key_rows [$];
    int          err_count   = 0;
    int          cycle_count = 0;
    int          last_count  = 0;
    bit          idle_on     = 1'b1;
    bit          hold_req    = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned stall_left  = 0;

    hid_keyboard_report_builder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_usage_code   (i_usage_code),
        .i_pressed      (i_pressed),
        .i_force_shift  (i_force_shift),
        .i_force_ctrl   (i_force_ctrl),
        .i_force_alt    (i_force_alt),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_modifier_byte(o_modifier_byte),
        .o_slot_0       (o_slot_0),
        .o_slot_1       (o_slot_1),
        .o_slot_2       (o_slot_2),
        .o_slot_3       (o_slot_3),
        .o_slot_4       (o_slot_4),
        .o_slot_5       (o_slot_5),
        .o_last_report  (o_last_report)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_report snapshot_report(bit last);
        t_report r;
        int      pos;
        r   = '0;
        pos = 0;
        for (int m = 0; m < hkrb_pkg::NUM_MODIFIERS; m++) begin
            if (held_keys[hkrb_pkg::MOD_BASE + m]) r.mods[m] = 1'b1;
        end
        for (int k = 1; k < hkrb_pkg::MOD_BASE; k++) begin
            if (held_keys[k] && pos < hkrb_pkg::REPORT_SLOTS) begin
                r.slot[pos] = 8'(k);
                pos++;
            end
        end
        r.last = last;
        return r;
    endfunction

    // updates the key map and fills event_reports, returns the report count
    function automatic int apply_key_event(logic [7:0] code, bit down, bit fs, bit fc, bit fa);
        bit sh, ct, al;
        if (code == 0 || code >= hkrb_pkg::NUM_KEYS) return 0;
        if (held_keys[code] == down) return 0;
        if (!down) begin
            held_keys[code]  = 1'b0;
            event_reports[0] = snapshot_report(1'b1);
            return 1;
        end
        sh = fs && !held_keys[CODE_LSHIFT];
        ct = fc && !held_keys[CODE_LCTRL];
        al = fa && !held_keys[CODE_LALT];
        if (sh) held_keys[CODE_LSHIFT] = 1'b1;
        if (ct) held_keys[CODE_LCTRL] = 1'b1;
        if (al) held_keys[CODE_LALT] = 1'b1;
        event_reports[0] = snapshot_report(1'b0);
        held_keys[code]  = 1'b1;
        event_reports[1] = snapshot_report(1'b0);
        if (sh) held_keys[CODE_LSHIFT] = 1'b0;
        if (ct) held_keys[CODE_LCTRL] = 1'b0;
        if (al) held_keys[CODE_LALT] = 1'b0;
        event_reports[2] = snapshot_report(1'b1);
        return 3;
    endfunction

    function automatic t_report make_report(logic [7:0] mods, logic [7:0] s0, bit last);
        t_report r;
        r         = '0;
        r.mods    = mods;
        r.slot[0] = s0;
        r.last    = last;
        return r;
    endfunction

    task automatic add_row(logic [7:0] code, bit down, bit fs, bit fc, bit fa);
        t_key_row row;
        row      = '0;
        row.code = code;
        row.down = down;
        row.fs   = fs;
        row.fc   = fc;
        row.fa   = fa;
        key_rows.push_back(row);
    endtask

    task automatic add_typed(logic [7:0] code, bit down, bit fs, bit fc, bit fa,
                             int n, t_report r0, t_report r1, t_report r2);
        t_key_row row;
        row         = '0;
        row.code    = code;
        row.down    = down;
        row.fs      = fs;
        row.fc      = fc;
        row.fa      = fa;
        row.typed   = 1'b1;
        row.n_typed = 2'(n);
        row.rep[0]  = r0;
        row.rep[1]  = r1;
        row.rep[2]  = r2;
        key_rows.push_back(row);
    endtask

    // offers one key event and books its reports at the transfer
    task automatic send_event(t_key_row row);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_usage_code  <= row.code;
        i_pressed     <= row.down;
        i_force_shift <= row.fs;
        i_force_ctrl  <= row.fc;
        i_force_alt   <= row.fa;
        do @(posedge i_clk); while (o_stall);
        last_count = apply_key_event(row.code, row.down, row.fs, row.fc, row.fa);
        if (row.typed) begin
            for (int i = 0; i < row.n_typed; i++) pending_reports.push_back(row.rep[i]);
        end else begin
            for (int i = 0; i < last_count; i++) pending_reports.push_back(event_reports[i]);
        end
    endtask

    task automatic check_report();
        t_report got, want;
        bit      bad;
        got.mods    = o_modifier_byte;
        got.slot[0] = o_slot_0;
        got.slot[1] = o_slot_1;
        got.slot[2] = o_slot_2;
        got.slot[3] = o_slot_3;
        got.slot[4] = o_slot_4;
        got.slot[5] = o_slot_5;
        got.last    = o_last_report;
        if (pending_reports.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected report mods %0h slots %p last %0d",
                         got.mods, got.slot, got.last);
            return;
        end
        want = pending_reports.pop_front();
        bad  = (got.mods !== want.mods) || (got.last !== want.last);
        for (int i = 0; i < hkrb_pkg::SLOT_FIELDS; i++) begin
            if (got.slot[i] !== want.slot[i]) bad = 1'b1;
        end
        if (bad) begin
            err_count++;
            if (err_count <= 10)
                $display({"report mismatch: expected mods %0h slots %p last %0d,",
                          " got mods %0h slots %p last %0d"},
                         want.mods, want.slot, want.last, got.mods, got.slot, got.last);
        end
    endtask

    // output side: checks each transfer, then picks the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_report();
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_key_row    row;
        int          n;
        int unsigned sel;
        bit          hold_issued, paused;

        hold_issued = 1'b0;
        paused      = 1'b0;

        // directed events
        add_typed(8'd4, 0, 0, 0, 0, 0, '0, '0, '0);
        add_typed(8'd0, 1, 1, 1, 1, 0, '0, '0, '0);
        add_typed(8'd255, 1, 0, 0, 0, 0, '0, '0, '0);
        add_typed(8'(hkrb_pkg::NUM_KEYS), 1, 1, 0, 0, 0, '0, '0, '0);
        add_typed(8'd1, 1, 0, 0, 0, 3, make_report(8'h00, 8'd0, 0),
                  make_report(8'h00, 8'd1, 0), make_report(8'h00, 8'd1, 1));
        add_typed(8'd1, 1, 0, 0, 0, 0, '0, '0, '0);
        add_typed(8'd1, 0, 0, 0, 0, 1, make_report(8'h00, 8'd0, 1), '0, '0);
        add_typed(8'(KEY_TOP), 1, 1, 1, 1, 3,
                  make_report(MASK_LCTRL | MASK_LSHIFT | MASK_LALT, 8'd0, 0),
                  make_report(MASK_LCTRL | MASK_LSHIFT | MASK_LALT, 8'(KEY_TOP), 0),
                  make_report(8'h00, 8'(KEY_TOP), 1));
        add_row(8'(KEY_RGUI), 1, 1, 1, 1);
        add_row(8'(CODE_LSHIFT), 1, 1, 0, 0);
        add_row(8'(CODE_LSHIFT), 1, 0, 0, 0);
        add_row(8'd5, 1, 1, 1, 0);
        add_row(8'(CODE_LSHIFT), 0, 0, 0, 0);
        add_row(8'(KEY_TOP), 0, 1, 1, 1);
        for (int k = 10; k <= 16; k++) add_row(8'(k), 1, 0, 0, 0);
        add_row(8'd10, 0, 0, 0, 0);
        add_row(8'(CODE_LCTRL), 1, 0, 1, 1);
        add_row(8'(KEY_RGUI), 0, 0, 0, 0);
        add_row(8'(CODE_LCTRL), 0, 1, 1, 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (key_rows[i]) send_event(key_rows[i]);

        // random typing
        n = 0;
        while (n < RANDOM_EVENTS) begin
            idle_on = !(n >= 80 && n < 120) && n < 200;
            if (n == 40 && !hold_issued) begin
                hold_issued = 1'b1;
                hold_req    = 1'b1;
            end
            if (n == 150 && !paused) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_reports.size() != 0) @(posedge i_clk);
            end
            row = '0;
            sel = $urandom_range(0, 99);
            if (sel < 4)
                row.code = (sel < 2) ? 8'd0 : 8'($urandom_range(hkrb_pkg::NUM_KEYS, 255));
            else if (sel < 55)
                row.code = 8'($urandom_range(1, 12));
            else if (sel < 70)
                row.code = 8'(hkrb_pkg::MOD_BASE
                              + $urandom_range(0, hkrb_pkg::NUM_MODIFIERS - 1));
            else if (sel < 80)
                row.code = 8'($urandom_range(hkrb_pkg::MOD_BASE - 8, hkrb_pkg::MOD_BASE - 1));
            else
                row.code = 8'($urandom_range(1, hkrb_pkg::NUM_KEYS - 1));
            if ($urandom_range(0, 4) == 0)
                row.down = 1'($urandom_range(0, 1));
            else
                row.down = !held_keys[row.code];
            row.fs = 1'($urandom_range(0, 1));
            row.fc = 1'($urandom_range(0, 1));
            row.fa = 1'($urandom_range(0, 1));
            send_event(row);
            n++;
        end
        i_valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/hkrb_pkg.sv
src/hkrb_datapath.sv
src/hkrb_ctrl.sv
src/hid_keyboard_report_builder.sv
tb/testbench.sv
